>>> rtl/dnlw_pkg.sv
// ----------------------------------------------------------------------------
// dnlw_pkg
// Shared types and constants for the decimal number LCD writer.
// ----------------------------------------------------------------------------
package dnlw_pkg;

    localparam int unsigned NUMBER_W   = 31;  // input number width
    localparam int unsigned BCD_W      = 4;   // one decimal digit
    localparam int unsigned PATTERN_W  = 16;  // four row nibbles per position
    localparam int unsigned COUNT_W    = 4;   // holds up to eight positions
    localparam int unsigned WRITTEN_W  = 3;   // reported count width
    localparam int unsigned OUT_POS    = 5;   // positions shown on the ports
    localparam int unsigned BIT_CNT_W  = 5;   // indexes the number's bits

    // Per-cell control, driven by the sequencer.
    typedef struct packed {
        logic clear;   // zero the digit ahead of a conversion
        logic shift;   // one double-dabble step
        logic write;   // latch the segment pattern into the image
    } t_cell_ctrl;

    // Segment rows per digit, row k in bits 4k+3..4k.
    function automatic logic [PATTERN_W-1:0] digit_pattern(input logic [BCD_W-1:0] digit);
        logic [PATTERN_W-1:0] pat;
        case (digit)
            4'd0:    pat = 16'h1551;
            4'd1:    pat = 16'h0110;
            4'd2:    pat = 16'h1E11;
            4'd3:    pat = 16'h1B11;
            4'd4:    pat = 16'h0B50;
            4'd5:    pat = 16'h1B41;
            4'd6:    pat = 16'h1F41;
            4'd7:    pat = 16'h0111;
            4'd8:    pat = 16'h1F51;
            4'd9:    pat = 16'h1B51;
            default: pat = '0;
        endcase
        return pat;
    endfunction

    // 10^k for k = 0..7, the thresholds for the decimal digit count.
    function automatic logic [NUMBER_W-1:0] pow10(input int unsigned k);
        logic [NUMBER_W-1:0] val;
        case (k)
            0:       val = 31'd1;
            1:       val = 31'd10;
            2:       val = 31'd100;
            3:       val = 31'd1000;
            4:       val = 31'd10000;
            5:       val = 31'd100000;
            6:       val = 31'd1000000;
            7:       val = 31'd10000000;
            default: val = '1;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/dnlw_digit_cell.sv
// ----------------------------------------------------------------------------
// dnlw_digit_cell
// One decimal digit of the double-dabble chain plus its held LCD pattern.
// ----------------------------------------------------------------------------
module dnlw_digit_cell
    import dnlw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctrl           i_ctrl,
    input  logic                 i_bit,
    output logic                 o_bit,
    output logic [PATTERN_W-1:0] o_image
);

    logic [BCD_W-1:0]     r_bcd;
    logic [PATTERN_W-1:0] r_image;
    logic [BCD_W-1:0]     w_adj;

    // add 3 before the shift when the digit would overflow past 9
    assign w_adj   = (r_bcd >= 4'd5) ? r_bcd + 4'd3 : r_bcd;
    assign o_bit   = w_adj[BCD_W-1];
    assign o_image = r_image;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_bcd <= '0;
        end else if (i_ctrl.shift) begin
            r_bcd <= {w_adj[BCD_W-2:0], i_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image <= '0;
        end else if (i_ctrl.write) begin
            r_image <= digit_pattern(r_bcd);
        end
    end

endmodule

>>> rtl/decimal_number_lcd_writer_top.sv
// ----------------------------------------------------------------------------
// decimal_number_lcd_writer_top
// Writes the low decimal digits of a number into a held LCD digit image.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one beat carrying i_number.
//   Output channel (o_valid / i_ready) returns one beat per input beat: the
//   five leftmost position patterns of the held image and the number of
//   positions this number overwrote (zero writes nothing).
// Conversion:
//   A double-dabble step for each bit of the number, one bit per cycle
//   through the row of digit cells, then a write into the image and a load
//   of the output register. One number is converted at a time, so a new
//   beat is taken only once the previous result has been loaded.
// Reset:
//   Synchronous, active low. Clears the image (all segments off), the
//   sequencer and the output valid.
// Stall:
//   The result sits in its own register; a finished conversion waits in the
//   load step while the previous result is still pending, and o_ready stays
//   low until it is handed over.
// ----------------------------------------------------------------------------
module decimal_number_lcd_writer_top
    import dnlw_pkg::*;
#(
    parameter int unsigned DIGIT_COUNT = 5   // positions in the image, 1..8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [NUMBER_W-1:0]  i_number,
    // output channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PATTERN_W-1:0] o_position0_pattern,
    output logic [PATTERN_W-1:0] o_position1_pattern,
    output logic [PATTERN_W-1:0] o_position2_pattern,
    output logic [PATTERN_W-1:0] o_position3_pattern,
    output logic [PATTERN_W-1:0] o_position4_pattern,
    output logic [WRITTEN_W-1:0] o_digits_written
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_WRITE,
        S_LOAD
    } t_state;

    t_state               r_state;
    logic [NUMBER_W-1:0]  r_shift;     // number, MSB first into the chain
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [COUNT_W-1:0]   r_count;     // positions to write for this beat
    logic [COUNT_W-1:0]   n_count;
    logic                 r_o_valid;
    logic [PATTERN_W-1:0] r_pos [OUT_POS];
    logic [WRITTEN_W-1:0] r_written;

    logic                 w_accept;
    logic                 w_load;
    logic [DIGIT_COUNT-1:0]   w_chain;          // serial bit into each cell
    logic [PATTERN_W-1:0]     w_image [DIGIT_COUNT];
    logic [PATTERN_W-1:0]     w_pos   [OUT_POS];

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_load   = (r_state == S_LOAD) && (!r_o_valid || i_ready);

    // Digit count = number of k < DIGIT_COUNT with number >= 10^k.
    always_comb begin
        n_count = '0;
        for (int unsigned k = 0; k < DIGIT_COUNT; k++) begin
            if (i_number >= pow10(k)) begin
                n_count = n_count + 4'd1;
            end
        end
    end

    // Row of digit cells: cell 0 is the least significant digit and feeds
    // the rightmost position; carries ripple toward higher cells each step.
    assign w_chain[0] = r_shift[NUMBER_W-1];

    for (genvar d = 0; d < DIGIT_COUNT; d++) begin : g_cell
        t_cell_ctrl w_ctrl;

        assign w_ctrl.clear = w_accept;
        assign w_ctrl.shift = (r_state == S_SHIFT);
        assign w_ctrl.write = (r_state == S_WRITE) && (COUNT_W'(d) < r_count);

        if (d < DIGIT_COUNT - 1) begin : g_mid
            dnlw_digit_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_bit   (w_chain[d]),
                .o_bit   (w_chain[d+1]),
                .o_image (w_image[d])
            );
        end else begin : g_last
            // top carry is dropped: only the low digits are shown
            dnlw_digit_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_bit   (w_chain[d]),
                .o_bit   (),
                .o_image (w_image[d])
            );
        end
    end

    // Position p (leftmost = 0) is held by cell DIGIT_COUNT-1-p.
    for (genvar p = 0; p < OUT_POS; p++) begin : g_pos
        if (p < DIGIT_COUNT) begin : g_held
            assign w_pos[p] = w_image[DIGIT_COUNT-1-p];
        end else begin : g_none
            assign w_pos[p] = '0;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count   <= n_count;
                        r_bit_cnt <= '0;
                        r_state   <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_bit_cnt <= r_bit_cnt + 5'd1;
                    if (r_bit_cnt == BIT_CNT_W'(NUMBER_W - 1)) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_shift <= i_number;
        end else if (r_state == S_SHIFT) begin
            r_shift <= {r_shift[NUMBER_W-2:0], 1'b0};
        end
        if (w_load) begin
            for (int p = 0; p < OUT_POS; p++) begin
                r_pos[p] <= w_pos[p];
            end
            r_written <= r_count[WRITTEN_W-1:0];
        end
    end

    assign o_valid             = r_o_valid;
    assign o_position0_pattern = r_pos[0];
    assign o_position1_pattern = r_pos[1];
    assign o_position2_pattern = r_pos[2];
    assign o_position3_pattern = r_pos[3];
    assign o_position4_pattern = r_pos[4];
    assign o_digits_written    = r_written;

endmodule

>>> dv/decimal_number_lcd_writer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_number_lcd_writer_top_test
// Self-checking bench for the decimal number LCD writer.
// ----------------------------------------------------------------------------
// A table of hand-picked numbers runs first. These are extremes, every digit
// glyph, zero after reset and zero after a write. A long random run follows.
// It is biased toward every decimal length, toward the edges of each length and
// toward full 31-bit values. A local model of the held LCD image predicts
// each result beat, and the bench compares all fields of every beat. Both
// channels idle at random, and the sender drains the pipe now and then.
// ----------------------------------------------------------------------------
module decimal_number_lcd_writer_top_test;
    import dnlw_pkg::*;

    localparam int unsigned DIGIT_COUNT  = 5;
    localparam int unsigned IMAGE_SLOTS  = 8;           // model holds up to eight positions
    localparam longint      MAX_NUMBER   = 64'h7FFF_FFFF;
    localparam int unsigned RANDOM_BEATS = 1330;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;

    // Segment rows per glyph, row k in bits 4k+3..4k.
    localparam logic [PATTERN_W-1:0] GLYPH_ROWS [0:9] = '{
        16'h1551, 16'h0110, 16'h1E11, 16'h1B11, 16'h0B50,
        16'h1B41, 16'h1F41, 16'h0111, 16'h1F51, 16'h1B51
    };

    // One result beat: position 0 is the leftmost digit.
    typedef struct packed {
        logic [0:OUT_POS-1][PATTERN_W-1:0] pattern;
        logic [WRITTEN_W-1:0]              written;
    } t_lcd_frame;

    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic                typed;    // frame below is the expectation
        t_lcd_frame          frame;
    } t_digit_row;

    localparam t_lcd_frame NO_FRAME = '0;

    // Directed stimulus. Typed rows carry frames that can be read straight
    // off the glyph table; the rest go through the image model.
    localparam int unsigned DIRECTED_ROWS = 22;
    localparam t_digit_row DIGIT_ROWS [0:DIRECTED_ROWS-1] = '{
        // zero right after reset: blank image, nothing written
        '{31'd0,          1'b1, '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 3'd0}},
        '{31'd1,          1'b1, '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0110}, 3'd1}},
        // zero keeps the image as it is
        '{31'd0,          1'b1, '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0110}, 3'd0}},
        '{31'd10,         1'b0, NO_FRAME},
        '{31'd12345,      1'b0, NO_FRAME},
        '{31'd42,         1'b0, NO_FRAME},
        '{31'd99999,      1'b1, '{'{16'h1B51, 16'h1B51, 16'h1B51, 16'h1B51, 16'h1B51}, 3'd5}},
        // six digits: only the low five reach the display
        '{31'd100000,     1'b1, '{'{16'h1551, 16'h1551, 16'h1551, 16'h1551, 16'h1551}, 3'd5}},
        '{31'd7,          1'b0, NO_FRAME},
        '{31'd2147483647, 1'b1, '{'{16'h1F51, 16'h1B11, 16'h1F41, 16'h0B50, 16'h0111}, 3'd5}},
        '{31'd0,          1'b1, '{'{16'h1F51, 16'h1B11, 16'h1F41, 16'h0B50, 16'h0111}, 3'd0}},
        '{31'd1234567890, 1'b1, '{'{16'h1F41, 16'h0111, 16'h1F51, 16'h1B51, 16'h1551}, 3'd5}},
        '{31'd305,        1'b0, NO_FRAME},
        '{31'd1000,       1'b0, NO_FRAME},
        '{31'd9999,       1'b0, NO_FRAME},
        '{31'd10000,      1'b0, NO_FRAME},
        '{31'd86,         1'b0, NO_FRAME},
        '{31'd1073741824, 1'b0, NO_FRAME},
        '{31'd715827882,  1'b0, NO_FRAME},
        '{31'd1431655765, 1'b0, NO_FRAME},
        '{31'd65536,      1'b0, NO_FRAME},
        '{31'd9,          1'b0, NO_FRAME}
    };

    // ------------------------------------------------------------------------
    // DUT hookup. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 i_valid  = 1'b0;
    logic [NUMBER_W-1:0]  i_number = '0;
    logic                 i_ready  = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [PATTERN_W-1:0] o_position0_pattern;
    logic [PATTERN_W-1:0] o_position1_pattern;
    logic [PATTERN_W-1:0] o_position2_pattern;
    logic [PATTERN_W-1:0] o_position3_pattern;
    logic [PATTERN_W-1:0] o_position4_pattern;
    logic [WRITTEN_W-1:0] o_digits_written;

    decimal_number_lcd_writer_top #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_number           (i_number),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_position0_pattern(o_position0_pattern),
        .o_position1_pattern(o_position1_pattern),
        .o_position2_pattern(o_position2_pattern),
        .o_position3_pattern(o_position3_pattern),
        .o_position4_pattern(o_position4_pattern),
        .o_digits_written   (o_digits_written)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Image model and bookkeeping
    // ------------------------------------------------------------------------
    logic [PATTERN_W-1:0] lcd_image [0:IMAGE_SLOTS-1];
    t_lcd_frame           frames_due [$];     // predicted beats, oldest first

    // Sideband for the beat on the bus. It changes together with i_valid, so
    // the monitor sees the flag of the beat that is accepted.
    logic                 typed_due   = 1'b0;
    t_lcd_frame           typed_frame = '0;
    logic                 steady_sink = 1'b1;

    int unsigned fault_count   = 0;
    int unsigned sent_count    = 0;
    int unsigned checked_count = 0;
    int unsigned zero_count    = 0;
    int unsigned full_count    = 0;
    int unsigned longest_stall = 0;
    int unsigned stall_run     = 0;
    int unsigned cycle_count   = 0;

    t_lcd_frame predicted_frame;
    t_lcd_frame got_frame;
    t_lcd_frame want_frame;

    // Writes the low digits of value into the held image, rightmost first.
    // Stops once the quotient runs out, so zero leaves the image untouched.
    function automatic t_lcd_frame show_number(input logic [NUMBER_W-1:0] value);
        t_lcd_frame  frame;
        logic [31:0] rest;
        int unsigned span;
        int unsigned count;
        span  = (DIGIT_COUNT > IMAGE_SLOTS) ? IMAGE_SLOTS : DIGIT_COUNT;
        rest  = 32'(value);
        count = 0;
        while (count < span && rest != 0) begin
            lcd_image[(span - 1 - count) % IMAGE_SLOTS] = GLYPH_ROWS[rest % 10];
            rest  = rest / 10;
            count = count + 1;
        end
        for (int p = 0; p < OUT_POS; p++) begin
            frame.pattern[p] = (p < span) ? lcd_image[p] : '0;
        end
        frame.written = WRITTEN_W'(count);   // count of eight wraps to zero
        return frame;
    endfunction

    // Idle and stall lengths: mostly short, some medium, a few long.
    function automatic int unsigned pick_span();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(0, 3);
        end else if (roll < 95) begin
            return $urandom_range(4, 40);
        end
        return $urandom_range(41, 200);
    endfunction

    // Random numbers spread over every decimal length, with the edges
    // 10^k - 1 and 10^k, zero, and raw 31-bit values mixed in.
    function automatic logic [NUMBER_W-1:0] pick_number();
        longint      lo;
        longint      hi;
        int unsigned roll;
        int unsigned digits;
        roll   = $urandom_range(0, 9);
        digits = $urandom_range(1, 10);
        lo     = 1;
        for (int k = 1; k < digits; k++) begin
            lo = lo * 10;
        end
        hi = lo * 10 - 1;
        if (hi > MAX_NUMBER) begin
            hi = MAX_NUMBER;
        end
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return NUMBER_W'($urandom);
        end else if (roll == 2) begin
            return NUMBER_W'(($urandom_range(0, 1) != 0) ? lo : hi);
        end
        return NUMBER_W'(lo + longint'($urandom) % (hi - lo + 1));
    endfunction

    // Puts one beat on the input channel and returns once it is accepted.
    // Valid is left high; the caller lowers it only when a gap follows.
    task automatic send_number(input logic [NUMBER_W-1:0] value, input logic typed,
                               input t_lcd_frame frame);
        i_valid     <= 1'b1;
        i_number    <= value;
        typed_due   <= typed;
        typed_frame <= frame;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: values are sampled at the rising edge, before this edge's
    // updates land, so both sides see what the DUT saw.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            predicted_frame = show_number(i_number);
            frames_due.push_back(typed_due ? typed_frame : predicted_frame);
            sent_count = sent_count + 1;
            if (i_number == '0) begin
                zero_count = zero_count + 1;
            end
            if (predicted_frame.written == WRITTEN_W'(DIGIT_COUNT)) begin
                full_count = full_count + 1;
            end
        end

        if (i_rst_n && o_valid && !i_ready) begin
            stall_run = stall_run + 1;
            if (stall_run > longest_stall) begin
                longest_stall = stall_run;
            end
        end else begin
            stall_run = 0;
        end

        if (i_rst_n && o_valid && i_ready) begin
            got_frame.pattern[0] = o_position0_pattern;
            got_frame.pattern[1] = o_position1_pattern;
            got_frame.pattern[2] = o_position2_pattern;
            got_frame.pattern[3] = o_position3_pattern;
            got_frame.pattern[4] = o_position4_pattern;
            got_frame.written    = o_digits_written;
            if (frames_due.size() == 0) begin
                $display("%0t: result beat with nothing expected (written %0d)",
                         $realtime, got_frame.written);
                fault_count = fault_count + 1;
            end else begin
                want_frame    = frames_due.pop_front();
                checked_count = checked_count + 1;
                for (int p = 0; p < OUT_POS; p++) begin
                    if (got_frame.pattern[p] !== want_frame.pattern[p]) begin
                        $display("%0t: position%0d_pattern expected %h actual %h",
                                 $realtime, p, want_frame.pattern[p],
                                 got_frame.pattern[p]);
                        fault_count = fault_count + 1;
                    end
                end
                if (got_frame.written !== want_frame.written) begin
                    $display("%0t: digits_written expected %0d actual %0d",
                             $realtime, want_frame.written, got_frame.written);
                    fault_count = fault_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink pacing: ready stretches and stalls of random length, held high
    // throughout while the stimulus asks for a calm stretch.
    // ------------------------------------------------------------------------
    initial begin : sink_pacing
        int unsigned span;
        @(posedge i_clk);
        forever begin
            if (steady_sink) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                span = pick_span();
                i_ready <= ($urandom_range(0, 2) != 0);
                repeat (span + 1) @(posedge i_clk);
            end
        end
    end

    // Watchdog: a correct run stays far below this.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d beats still expected", $realtime, frames_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned hold;
        logic        calm;
        logic        pause;
        foreach (lcd_image[s]) begin
            lcd_image[s] = '0;   // image is blank after reset
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows go back to back, with the sink always ready.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_number(DIGIT_ROWS[r].number, DIGIT_ROWS[r].typed, DIGIT_ROWS[r].frame);
        end

        // Random part. Every fourth block of 150 beats is a calm stretch with
        // no idling on either side; elsewhere both sides idle at random. The
        // sender drains the pipe at the midpoint and now and then at random.
        for (int k = 0; k < RANDOM_BEATS; k++) begin
            calm  = ((k / 150) % 4) == 1;
            pause = (k == RANDOM_BEATS / 2) || ($urandom_range(0, 199) == 0);
            hold  = calm ? 0 : pick_span();
            steady_sink <= calm;
            if (hold > 0 || pause) begin
                i_valid  <= 1'b0;
                i_number <= NUMBER_W'($urandom);   // junk while idle
                repeat (hold) @(posedge i_clk);
                if (pause) begin
                    @(posedge i_clk);
                    while (frames_due.size() != 0) begin
                        @(posedge i_clk);
                    end
                end
            end
            send_number(pick_number(), 1'b0, NO_FRAME);
        end
        i_valid <= 1'b0;

        // Let the last beats drain, then watch for strays.
        while (frames_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d numbers in (%0d from the table), %0d result beats checked",
                 sent_count, DIRECTED_ROWS, checked_count);
        $display("     %0d zeros, %0d full-width writes, longest sink stall %0d cycles",
                 zero_count, full_count, longest_stall);
        if (fault_count == 0 && frames_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
